### hw/rtl/imm_band_pkg.sv
`timescale 1ns / 1ps
package imm_band_pkg;

  localparam int MAX_SIZE  = 16;
  localparam int IDX_W     = $clog2(MAX_SIZE);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int ROW_W     = $clog2(MAX_SIZE + 1);

  localparam int SIZE_W = 5;
  localparam int CNT_W  = 5;
  localparam int PIDX_W = 4;
  localparam int DVD_W  = PIDX_W + 1 + SIZE_W;
  localparam int DCNT_W = $clog2(DVD_W);

  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    KIND_WR_A    = 2'd0,
    KIND_WR_B    = 2'd1,
    KIND_COMPUTE = 2'd2,
    KIND_RD_C    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_SIZE  = 2'd0,
    REG_COUNT = 2'd1,
    REG_INDEX = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BND,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_MAC,
    ST_DRAIN,
    ST_RD
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               in_band;
    logic               done_res;
  } out_res_t;

endpackage

### hw/rtl/int_matrix_multiply_row_band.sv
// Results: an A or B write gives none; a C read gives its result strobe from the ST_RD state
// via out_strobe_r; a compute runs a MAC per band row, column and term, then strobes done.
// One shared 32x32 multiply-accumulate fed by the A and B memory read ports sets compute time.
// A config write holds busy while a shared restoring divider finds low, then high band rows.
// Reset (sync, active low): regs to n=16, count=1, index=0; C reads as zero until computed.
// Results cannot be stalled by the receiver: out_strobe is high for one cycle per result.
`timescale 1ns / 1ps
module int_matrix_multiply_row_band import imm_band_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_req_t             in_req,
  output logic                out_strobe,
  output out_res_t            out_res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0] size_r;
  logic [CNT_W-1:0]  count_r;
  logic [PIDX_W-1:0] pidx_r;

  logic [ROW_W-1:0] lo_r, hi_r;

  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;
  logic [DCNT_W-1:0] dcnt_r;
  logic              div_last;

  logic [IDX_W-1:0] r_r, c_r, i_r;
  logic             last_i, last_c, last_r;

  logic [DATA_W-1:0] a_mem [MEM_DEPTH];
  logic [DATA_W-1:0] b_mem [MEM_DEPTH];
  logic [DATA_W-1:0] c_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] c_vld_r;

  logic [DATA_W-1:0] a_q, b_q, c_q;
  logic              c_hit_q;
  logic [IDX_W-1:0]  rd_row_r;

  logic              s1_v_r, s1_first_r, s1_last_r;
  logic [ADDR_W-1:0] s1_caddr_r;
  logic              s2_v_r, s2_first_r, s2_last_r;
  logic [ADDR_W-1:0] s2_caddr_r;
  logic [DATA_W-1:0] prod_r, acc_r, acc_sum;

  logic              out_strobe_r;
  out_res_t          out_res_r;

  logic              cfg_wr, accept, issue, emit_rd, emit_done, band_empty, cfg_empty;
  logic [SIZE_W-1:0] n_use;
  logic [ROW_W-1:0]  n_m1, hi_m1;
  logic [ADDR_W-1:0] in_addr;
  reg_idx_t          reg_sel;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign busy    = (state_r != ST_IDLE) || cfg_wr;
  assign accept  = start && !busy;
  assign in_addr = {in_req.row, in_req.col};

  assign n_use      = (size_r > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_r;
  assign n_m1       = ROW_W'(n_use) - ROW_W'(1);
  assign hi_m1      = hi_r - ROW_W'(1);
  assign band_empty = (lo_r >= hi_r);
  assign cfg_empty  = (n_use == '0) || (count_r == '0) || (CNT_W'(pidx_r) >= count_r);

  assign last_i = (ROW_W'(i_r) == n_m1);
  assign last_c = (ROW_W'(c_r) == n_m1);
  assign last_r = (ROW_W'(r_r) == hi_m1);

  // restoring divide step, quotient shifts into the dividend register
  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, count_r});
  assign rem_nxt  = rem_ge ? CNT_W'(rem_sh - {1'b0, count_r}) : CNT_W'(rem_sh);
  assign dvd_nxt  = {dvd_r[DVD_W-2:0], rem_ge};
  assign div_last = (dcnt_r == DCNT_W'(DVD_W - 1));

  assign acc_sum = (s2_first_r ? '0 : acc_r) + prod_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    if (cfg_wr) begin
      state_nxt = ST_BND;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_req.kind)
              KIND_COMPUTE: state_nxt = band_empty ? ST_DRAIN : ST_MAC;
              KIND_RD_C:    state_nxt = ST_RD;
              default:      state_nxt = ST_IDLE;
            endcase
          end
        end
        ST_BND:    state_nxt = ST_DIV_LO;
        ST_DIV_LO: if (div_last) state_nxt = ST_DIV_HI;
        ST_DIV_HI: if (div_last) state_nxt = ST_IDLE;
        ST_MAC:    if (last_i && last_c && last_r) state_nxt = ST_DRAIN;
        ST_DRAIN:  if (!s1_v_r && !s2_v_r) state_nxt = ST_IDLE;
        ST_RD:     state_nxt = ST_IDLE;
        default:   state_nxt = ST_IDLE;
      endcase
    end
  end

  // ---------------- state outputs ----------------
  always_comb begin
    issue     = 1'b0;
    emit_rd   = 1'b0;
    emit_done = 1'b0;
    unique case (state_r)
      ST_MAC:   issue     = 1'b1;
      ST_DRAIN: emit_done = !s1_v_r && !s2_v_r;
      ST_RD:    emit_rd   = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- config registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= SIZE_W'(MAX_SIZE);
      count_r <= CNT_W'(1);
      pidx_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SIZE:  size_r  <= pwdata[SIZE_W-1:0];
        REG_COUNT: count_r <= pwdata[CNT_W-1:0];
        REG_INDEX: pidx_r  <= pwdata[PIDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SIZE:  prdata = DATA_W'(size_r);
      REG_COUNT: prdata = DATA_W'(count_r);
      REG_INDEX: prdata = DATA_W'(pidx_r);
      default:   prdata = '0;
    endcase
  end

  // ---------------- band bounds ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= '0;
      hi_r   <= ROW_W'(MAX_SIZE);
      dvd_r  <= '0;
      rem_r  <= '0;
      dcnt_r <= '0;
    end else begin
      case (state_r)
        ST_BND: begin
          dvd_r  <= DVD_W'(pidx_r) * DVD_W'(n_use);
          rem_r  <= '0;
          dcnt_r <= '0;
        end
        ST_DIV_LO: begin
          if (div_last) begin
            lo_r   <= ROW_W'(dvd_nxt);
            dvd_r  <= (DVD_W'(pidx_r) + DVD_W'(1)) * DVD_W'(n_use);
            rem_r  <= '0;
            dcnt_r <= '0;
          end else begin
            dvd_r  <= dvd_nxt;
            rem_r  <= rem_nxt;
            dcnt_r <= dcnt_r + DCNT_W'(1);
          end
        end
        ST_DIV_HI: begin
          dvd_r  <= dvd_nxt;
          rem_r  <= rem_nxt;
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (div_last) begin
            if (cfg_empty) begin
              lo_r <= '0;
              hi_r <= '0;
            end else if (dvd_nxt > DVD_W'(n_use)) begin
              hi_r <= ROW_W'(n_use);
            end else begin
              hi_r <= ROW_W'(dvd_nxt);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- MAC sequencer ----------------
  always_ff @(posedge clk) begin
    if (accept && in_req.kind == KIND_COMPUTE) begin
      r_r <= lo_r[IDX_W-1:0];
      c_r <= '0;
      i_r <= '0;
    end else if (issue) begin
      if (last_i) begin
        i_r <= '0;
        if (last_c) begin
          c_r <= '0;
          r_r <= r_r + IDX_W'(1);
        end else begin
          c_r <= c_r + IDX_W'(1);
        end
      end else begin
        i_r <= i_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (i_r == '0);
    s1_last_r  <= last_i;
    s1_caddr_r <= {r_r, c_r};
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_caddr_r <= s1_caddr_r;
    prod_r     <= DATA_W'(a_q * b_q);
    if (s2_v_r) begin
      acc_r <= acc_sum;
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (accept && in_req.kind == KIND_WR_A) begin
      a_mem[in_addr] <= in_req.value;
    end
    a_q <= a_mem[{r_r, i_r}];
  end

  always_ff @(posedge clk) begin
    if (accept && in_req.kind == KIND_WR_B) begin
      b_mem[in_addr] <= in_req.value;
    end
    b_q <= b_mem[{i_r, c_r}];
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_last_r) begin
      c_mem[s2_caddr_r] <= acc_sum;
    end
    c_q <= c_mem[in_addr];
  end

  // C reads as zero until an entry is first computed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= '0;
    end else if (s2_v_r && s2_last_r) begin
      c_vld_r[s2_caddr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_hit_q  <= c_vld_r[in_addr];
      rd_row_r <= in_req.row;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit_rd || emit_done;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_rd) begin
      out_res_r.value_res <= c_hit_q ? c_q : '0;
      out_res_r.in_band   <= (ROW_W'(rd_row_r) >= lo_r) && (ROW_W'(rd_row_r) < hi_r);
      out_res_r.done_res  <= 1'b0;
    end else if (emit_done) begin
      out_res_r.value_res <= '0;
      out_res_r.in_band   <= 1'b0;
      out_res_r.done_res  <= 1'b1;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

### dv/int_matrix_multiply_row_band_tb.sv
`timescale 1ns / 1ps
module int_matrix_multiply_row_band_tb;
  import imm_band_pkg::*;

  localparam int RANDOM_ITEMS   = 1550;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;

  // Keeps its own copy of the A, B and C stores and of the band registers,
  // and holds the results still owed by the block, oldest first.
  class matmul_band_model;
    logic [31:0] a_mem [MEM_DEPTH];
    logic [31:0] b_mem [MEM_DEPTH];
    logic [31:0] c_mem [MEM_DEPTH];
    bit          a_known [MEM_DEPTH];
    bit          b_known [MEM_DEPTH];
    logic [4:0]  size_reg;
    logic [4:0]  count_reg;
    logic [3:0]  index_reg;
    out_res_t    owed_results[$];
    int          mismatches;

    function new();
      for (int k = 0; k < MEM_DEPTH; k++) begin
        a_mem[k]   = '0;
        b_mem[k]   = '0;
        c_mem[k]   = '0;
        a_known[k] = 1'b0;
        b_known[k] = 1'b0;
      end
      size_reg   = 5'd16;
      count_reg  = 5'd1;
      index_reg  = 4'd0;
      mismatches = 0;
    endfunction

    function void write_register(reg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_SIZE:  size_reg  = data[4:0];
        REG_COUNT: count_reg = data[4:0];
        REG_INDEX: index_reg = data[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned size_used();
      return (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
    endfunction

    // rows [lo, hi) of the band; empty when lo >= hi
    function void band_rows(output int unsigned lo, output int unsigned hi);
      int unsigned n, cnt, idx, e;
      n   = size_used();
      cnt = count_reg;
      idx = index_reg;
      lo  = 0;
      hi  = 0;
      if (n == 0 || cnt == 0 || idx >= cnt) return;
      lo = idx * n / cnt;
      e  = (idx + 1) * n / cnt;
      hi = (e > n) ? n : e;
    endfunction

    function void note_request(in_req_t req);
      int unsigned lo, hi, n, addr;
      logic [31:0] acc;
      out_res_t    res;
      addr = req.row * MAX_SIZE + req.col;
      case (req.kind)
        KIND_WR_A: begin
          a_mem[addr]   = req.value;
          a_known[addr] = 1'b1;
        end
        KIND_WR_B: begin
          b_mem[addr]   = req.value;
          b_known[addr] = 1'b1;
        end
        KIND_COMPUTE: begin
          band_rows(lo, hi);
          n = size_used();
          for (int unsigned r = lo; r < hi; r++) begin
            for (int unsigned c = 0; c < n; c++) begin
              acc = '0;
              for (int unsigned i = 0; i < n; i++)
                acc = acc + a_mem[r * MAX_SIZE + i] * b_mem[i * MAX_SIZE + c];
              c_mem[r * MAX_SIZE + c] = acc;
            end
          end
          res.value_res = '0;
          res.in_band   = 1'b0;
          res.done_res  = 1'b1;
          owed_results.push_back(res);
        end
        default: begin
          band_rows(lo, hi);
          res.value_res = c_mem[addr];
          res.in_band   = (req.row >= lo && req.row < hi);
          res.done_res  = 1'b0;
          owed_results.push_back(res);
        end
      endcase
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result: value_res %0d in_band %0b done_res %0b",
               got.value_res, got.in_band, got.done_res);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (got.value_res !== want.value_res) begin
        $error("value_res: expected %0d, got %0d", want.value_res, got.value_res);
        mismatches++;
      end
      if (got.in_band !== want.in_band) begin
        $error("in_band: expected %0b, got %0b", want.in_band, got.in_band);
        mismatches++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_req_t             in_req;
  logic                out_strobe;
  out_res_t            out_res;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  matmul_band_model band_model = new();
  int               quiet_cycles;
  int               items_sent;

  int_matrix_multiply_row_band i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // results are checked before the request of the same edge is noted
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (out_strobe) band_model.check_result(out_res);
      if (start && !busy) band_model.note_request(in_req);
      if (out_strobe || (start && !busy) || (psel && penable && pwrite && pready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("int_matrix_multiply_row_band_tb NOT OK");
    $finish;
  end

  function automatic in_req_t make_req(kind_t k, int unsigned r, int unsigned c,
                                       logic [31:0] v);
    in_req_t req;
    req.kind  = k;
    req.row   = r[3:0];
    req.col   = c[3:0];
    req.value = v;
    return req;
  endfunction

  function automatic logic [31:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    if (pick < 50) return $urandom_range(0, 200) - 100;
    return $urandom;
  endfunction

  // index within the matrix in use most of the time, anywhere in the store otherwise
  function automatic int unsigned rand_index();
    int unsigned n;
    n = band_model.size_used();
    if (n != 0 && $urandom_range(0, 99) < 80) return $urandom_range(0, n - 1);
    return $urandom_range(0, MAX_SIZE - 1);
  endfunction

  // start stays high across back-to-back requests
  task automatic send_request(in_req_t req);
    @(negedge clk);
    start  = 1'b1;
    in_req = req;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (band_model.owed_results.size() != 0) @(negedge clk);
    // element writes give no result, let the last one settle
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [31:0] data);
    wait_idle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    band_model.write_register(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // upper bits are junk the block has to drop
  task automatic set_band(int unsigned size, int unsigned count, int unsigned index);
    write_register(REG_SIZE, {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, size[4:0]});
    write_register(REG_COUNT, {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, count[4:0]});
    write_register(REG_INDEX, {$urandom_range(0, 1) ? 28'($urandom) : 28'd0, index[3:0]});
  endtask

  // a compute must never touch an A or B entry that was never written
  task automatic run_compute();
    int unsigned lo, hi, n;
    band_model.band_rows(lo, hi);
    n = band_model.size_used();
    for (int unsigned r = lo; r < hi; r++)
      for (int unsigned i = 0; i < n; i++)
        if (!band_model.a_known[r * MAX_SIZE + i])
          send_request(make_req(KIND_WR_A, r, i, rand_value()));
    if (lo < hi) begin
      for (int unsigned i = 0; i < n; i++)
        for (int unsigned c = 0; c < n; c++)
          if (!band_model.b_known[i * MAX_SIZE + c])
            send_request(make_req(KIND_WR_B, i, c, rand_value()));
    end
    send_request(make_req(KIND_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom));
  endtask

  task automatic random_phase_config();
    int unsigned size, count, index, pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)      size = $urandom_range(1, 4);
    else if (pick < 75) size = $urandom_range(5, 8);
    else if (pick < 85) size = 16;
    else if (pick < 92) size = $urandom_range(9, 15);
    else if (pick < 96) size = $urandom_range(17, 31);
    else                size = 0;
    pick = $urandom_range(0, 99);
    if (pick < 50)      count = $urandom_range(1, 4);
    else if (pick < 80) count = $urandom_range(5, 16);
    else if (pick < 90) count = $urandom_range(17, 31);
    else                count = 0;
    if (count != 0 && $urandom_range(0, 99) < 80)
      index = $urandom_range(0, (count > 16 ? 16 : count) - 1);
    else
      index = $urandom_range(0, 15);
    set_band(size, count, index);
  endtask

  task automatic random_phase();
    int unsigned phase_items, burst_left, pick;
    phase_items = $urandom_range(50, 110);
    burst_left  = $urandom_range(1, 30);
    for (int k = 0; k < phase_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)
        send_request(make_req(KIND_WR_A, rand_index(), rand_index(), rand_value()));
      else if (pick < 55)
        send_request(make_req(KIND_WR_B, rand_index(), rand_index(), rand_value()));
      else if (pick < 92)
        send_request(make_req(KIND_RD_C, rand_index(), rand_index(), $urandom));
      else
        run_compute();
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
        burst_left = $urandom_range(1, 30);
      end
    end
  endtask

  initial begin
    int directed_items;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // C reads as zero after reset, whole matrix in band
    send_request(make_req(KIND_RD_C, 0, 0, 32'h0));
    send_request(make_req(KIND_RD_C, 15, 15, 32'hFFFF_FFFF));

    // one by one: wrap of the product
    set_band(1, 1, 0);
    send_request(make_req(KIND_WR_A, 0, 0, 32'h7FFF_FFFF));
    send_request(make_req(KIND_WR_B, 0, 0, 32'h7FFF_FFFF));
    run_compute();
    send_request(make_req(KIND_RD_C, 0, 0, 32'h0));
    send_request(make_req(KIND_RD_C, 1, 0, 32'h0));
    send_request(make_req(KIND_WR_A, 0, 0, 32'h8000_0000));
    send_request(make_req(KIND_WR_B, 0, 0, 32'hFFFF_FFFF));
    run_compute();
    send_request(make_req(KIND_RD_C, 0, 0, 32'h0));
    // entries past n are stored but unused
    send_request(make_req(KIND_WR_A, 15, 15, 32'h8000_0000));
    send_request(make_req(KIND_WR_B, 15, 0, 32'h0000_0000));
    send_request(make_req(KIND_RD_C, 15, 15, 32'h0));

    // empty bands: size zero, count zero, index past count
    set_band(0, 1, 0);
    run_compute();
    send_request(make_req(KIND_RD_C, 0, 0, 32'h0));
    set_band(16, 0, 0);
    run_compute();
    send_request(make_req(KIND_RD_C, 0, 0, 32'h0));
    set_band(16, 3, 5);
    run_compute();
    send_request(make_req(KIND_RD_C, 5, 3, 32'h0));

    // size past the store, last band of sixteen
    set_band(31, 16, 15);
    run_compute();
    send_request(make_req(KIND_RD_C, 15, 0, 32'h0));
    send_request(make_req(KIND_RD_C, 14, 15, 32'h0));
    directed_items = items_sent;

    while (items_sent - directed_items < RANDOM_ITEMS) begin
      random_phase_config();
      random_phase();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (band_model.owed_results.size() != 0) begin
      $error("%0d results never arrived", band_model.owed_results.size());
      band_model.mismatches++;
    end
    if (band_model.mismatches == 0) begin
      $display("int_matrix_multiply_row_band_tb OK");
    end else begin
      $display("int_matrix_multiply_row_band_tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/imm_band_pkg.sv
hw/rtl/int_matrix_multiply_row_band.sv
dv/int_matrix_multiply_row_band_tb.sv
